### rtl/core/uue_pkg.sv
// Shared types, constants and the fixed-text table for the uuencode line encoder.
// Used by uue_front, uue_queue, uue_back and the top level.
package uue_pkg;

    // Line length default and widths that cover the whole legal range (3 to 63)
    localparam int BPL_DEFAULT = 45;
    localparam int CNT_W       = 6;
    localparam int GRP_W       = 5;
    localparam int WORD_W      = 24;
    localparam int Q_DEPTH     = 2;

    // Fixed text: header at the start, trailer after it
    localparam int TXT_W     = 5;
    localparam int HDR_FIRST = 0;
    localparam int HDR_LAST  = 11;
    localparam int TRL_FIRST = 12;
    localparam int TRL_LAST  = 17;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h60;
    localparam logic [7:0] CH_NL    = 8'h0a;

    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_DATA    = 2'd1,
        ACT_END     = 2'd2,
        ACT_TRAILER = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_ENDED = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        K_HDR  = 2'd0,
        K_LINE = 2'd1,
        K_TRL  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TEXT,
        B_LEN,
        B_GROUP,
        B_QUOTE,
        B_NL
    } t_bstate;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out;

    // Command handed from front to back
    typedef struct packed {
        t_kind            kind;
        logic             bank;
        logic [CNT_W-1:0] cnt;
        logic [GRP_W-1:0] ngrp;
        logic             empty;
    } t_cmd;

    // Group word write into the line store
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [GRP_W-1:0]  word;
        logic [WORD_W-1:0] data;
    } t_wr;

    // Line store bank released by the back end
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

    function automatic logic [7:0] txt_char(input logic [TXT_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h62; // b
            5'd1:    c = 8'h65; // e
            5'd2:    c = 8'h67; // g
            5'd3:    c = 8'h69; // i
            5'd4:    c = 8'h6e; // n
            5'd5:    c = 8'h20;
            5'd6:    c = 8'h36; // 6
            5'd7:    c = 8'h36;
            5'd8:    c = 8'h36;
            5'd9:    c = 8'h20;
            5'd10:   c = 8'h2d; // -
            5'd11:   c = CH_NL;
            5'd12:   c = CH_QUOTE;
            5'd13:   c = CH_NL;
            5'd14:   c = 8'h65; // e
            5'd15:   c = 8'h6e; // n
            5'd16:   c = 8'h64; // d
            5'd17:   c = CH_NL;
            default: c = CH_NL;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/uue_front.sv
// Front end: accepts input transfers, tracks stream phase, packs bytes into group words.
// Depends on uue_pkg; writes the back end's line store and pushes commands to uue_queue.
module uue_front #(
    parameter int BYTES_PER_LINE = uue_pkg::BPL_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  uue_pkg::t_in   i_data,
    output logic           o_push,
    output uue_pkg::t_cmd  o_cmd,
    input  logic           i_q_full,
    output uue_pkg::t_wr   o_wr,
    input  uue_pkg::t_done i_done
);
    import uue_pkg::*;

    localparam logic [CNT_W-1:0] LINE_CNT = CNT_W'(BYTES_PER_LINE);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_pos, n_pos;
    logic [15:0]      r_part, n_part;
    logic [GRP_W-1:0] r_word, n_word;
    logic             r_wbank, n_wbank;
    logic             r_seen, n_seen;
    logic [1:0]       r_busy, n_busy;

    logic             accept;
    logic [CNT_W-1:0] cnt_inc;
    t_action          act;

    // Take an item only with room in the queue and a free bank to fill
    assign o_ready = !i_q_full && !r_busy[r_wbank];
    assign accept  = i_valid && o_ready;
    assign act     = t_action'(i_data.action);
    assign cnt_inc = r_cnt + CNT_W'(1);

    // Classify the accepted item and update the stream state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_part  = r_part;
        n_word  = r_word;
        n_wbank = r_wbank;
        n_seen  = r_seen;
        n_busy  = r_busy;
        o_push  = 1'b0;
        o_cmd   = '{kind: K_HDR, bank: r_wbank, cnt: r_cnt, ngrp: r_word, empty: 1'b0};
        o_wr    = '{en: 1'b0, bank: r_wbank, word: r_word, data: '0};

        if (i_done.valid) begin
            n_busy[i_done.bank] = 1'b0;
        end

        if (accept) begin
            unique case (act)
                ACT_BEGIN: begin
                    if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                        o_push     = 1'b1;
                        o_cmd.kind = K_HDR;
                        n_cnt      = '0;
                        n_pos      = '0;
                        n_word     = '0;
                        n_seen     = 1'b0;
                        n_phase    = PH_DATA;
                    end
                end
                ACT_DATA: begin
                    if (r_phase == PH_DATA) begin
                        n_seen = 1'b1;
                        n_cnt  = cnt_inc;
                        unique case (r_pos)
                            2'd1: begin
                                o_wr.data = {r_part[15:8], i_data.data_byte, 8'h00};
                                n_part[7:0] = i_data.data_byte;
                                n_pos = 2'd2;
                            end
                            2'd2: begin
                                o_wr.data = {r_part, i_data.data_byte};
                                n_pos = 2'd0;
                            end
                            default: begin
                                o_wr.data = {i_data.data_byte, 16'h0000};
                                n_part[15:8] = i_data.data_byte;
                                n_pos = 2'd1;
                            end
                        endcase
                        // Write the group word when full or when the line closes
                        if (r_pos == 2'd2 || cnt_inc == LINE_CNT) begin
                            o_wr.en = 1'b1;
                            n_word  = r_word + GRP_W'(1);
                        end
                        if (cnt_inc == LINE_CNT) begin
                            o_push          = 1'b1;
                            o_cmd.kind      = K_LINE;
                            o_cmd.cnt       = cnt_inc;
                            o_cmd.ngrp      = r_word + GRP_W'(1);
                            n_busy[r_wbank] = 1'b1;
                            n_wbank         = !r_wbank;
                            n_cnt           = '0;
                            n_pos           = '0;
                            n_word          = '0;
                        end
                    end
                end
                ACT_END: begin
                    if (r_phase == PH_DATA) begin
                        if (r_cnt != '0 || !r_seen) begin
                            o_push          = 1'b1;
                            o_cmd.kind      = K_LINE;
                            o_cmd.empty     = (r_cnt == '0);
                            o_cmd.ngrp      = (r_cnt == '0) ? GRP_W'(1) : r_word;
                            n_busy[r_wbank] = 1'b1;
                            n_wbank         = !r_wbank;
                        end
                        // Flush a partly filled group, zero padded
                        if (r_pos != 2'd0) begin
                            o_wr.en    = 1'b1;
                            o_wr.data  = (r_pos == 2'd1) ? {r_part[15:8], 16'h0000}
                                                         : {r_part, 8'h00};
                            o_cmd.ngrp = r_word + GRP_W'(1);
                        end
                        n_cnt   = '0;
                        n_pos   = '0;
                        n_word  = '0;
                        n_phase = PH_ENDED;
                    end
                end
                ACT_TRAILER: begin
                    if (r_phase == PH_ENDED) begin
                        o_push     = 1'b1;
                        o_cmd.kind = K_TRL;
                        n_phase    = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_word  <= '0;
            r_wbank <= 1'b0;
            r_seen  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_word  <= n_word;
            r_wbank <= n_wbank;
            r_seen  <= n_seen;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
    end

    // A line is never handed over from a bank still being read out
    a_line_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.kind == K_LINE |-> !r_busy[r_wbank])
        else $error("line pushed from a busy bank");

    // Group words are only written while data is being taken
    a_write_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> r_phase == PH_DATA)
        else $error("line store written outside data phase");

endmodule

### rtl/core/uue_queue.sv
// Short command queue between front and back ends.
// Depends on uue_pkg for the command type and depth.
module uue_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uue_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output uue_pkg::t_cmd o_head
);
    import uue_pkg::*;

    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QF_W = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QF_W-1:0] r_fill;

    assign o_full  = (r_fill == QF_W'(Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rp];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA_W'(Q_DEPTH - 1)) ? '0 : r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA_W'(Q_DEPTH - 1)) ? '0 : r_rp + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QF_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - QF_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");

endmodule

### rtl/core/uue_back.sv
// Back end: pops commands, reads group words from the line store, emits characters.
// Depends on uue_pkg; holds the two-bank line store and the output register.
module uue_back #(
    parameter int BYTES_PER_LINE = uue_pkg::BPL_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  uue_pkg::t_cmd  i_head,
    output logic           o_pop,
    input  uue_pkg::t_wr   i_wr,
    output uue_pkg::t_done o_done,
    output logic           o_valid,
    input  logic           i_ready,
    output uue_pkg::t_out  o_data
);
    import uue_pkg::*;

    localparam int GRP   = (BYTES_PER_LINE + 2) / 3;
    localparam int DEPTH = 2 * GRP;
    localparam int AW    = $clog2(DEPTH);

    t_bstate r_st, n_st;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [TXT_W-1:0] r_tidx, r_tlast;
    logic             r_bank;
    logic [CNT_W-1:0] r_cnt;
    logic [GRP_W-1:0] r_ngrp, r_gidx;
    logic [1:0]       r_cidx;
    logic             r_empty;

    logic             r_oval;
    t_out             r_odata;

    logic             adv;
    logic             last_grp;
    logic [7:0]       ch;
    logic             ch_last;
    logic             rd_en;
    logic [GRP_W-1:0] rd_word;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [5:0]       sextet;

    // Step when a character can go into the output register
    assign adv      = (r_st != B_IDLE) && (!r_oval || i_ready);
    assign last_grp = (r_gidx == r_ngrp - GRP_W'(1));
    assign o_valid  = r_oval;
    assign o_data   = r_odata;

    assign wr_addr = (i_wr.bank ? AW'(GRP) : '0) + AW'(i_wr.word);
    assign rd_addr = (r_bank ? AW'(GRP) : '0) + AW'(rd_word);

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_st = (i_head.kind == K_LINE) ? B_LEN : B_TEXT;
                end
            end
            B_TEXT: begin
                if (adv && r_tidx == r_tlast) begin
                    n_st = B_IDLE;
                end
            end
            B_LEN: begin
                if (adv) begin
                    n_st = B_GROUP;
                end
            end
            B_GROUP: begin
                if (adv && r_cidx == 2'd3 && last_grp) begin
                    n_st = B_QUOTE;
                end
            end
            B_QUOTE: begin
                if (adv) begin
                    n_st = B_NL;
                end
            end
            B_NL: begin
                if (adv) begin
                    n_st = B_IDLE;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    // Pick the six-bit field of the current group word
    always_comb begin
        unique case (r_cidx)
            2'd0:    sextet = r_rdata[23:18];
            2'd1:    sextet = r_rdata[17:12];
            2'd2:    sextet = r_rdata[11:6];
            default: sextet = r_rdata[5:0];
        endcase
        if (r_empty) begin
            sextet = '0;
        end
    end

    // Character, store read and bank release per state
    always_comb begin
        o_pop   = 1'b0;
        ch      = CH_NL;
        ch_last = 1'b0;
        rd_en   = 1'b0;
        rd_word = '0;
        o_done  = '{valid: 1'b0, bank: r_bank};
        unique case (r_st)
            B_IDLE: begin
                o_pop = !i_q_empty;
            end
            B_TEXT: begin
                ch      = txt_char(r_tidx);
                ch_last = (r_tidx == r_tlast);
            end
            B_LEN: begin
                ch      = CH_SPACE + {2'b00, r_cnt};
                rd_en   = adv;
                rd_word = '0;
            end
            B_GROUP: begin
                ch      = CH_SPACE + {2'b00, sextet};
                rd_en   = adv && r_cidx == 2'd3 && !last_grp;
                rd_word = r_gidx + GRP_W'(1);
            end
            B_QUOTE: begin
                ch = CH_QUOTE;
            end
            B_NL: begin
                ch           = CH_NL;
                ch_last      = 1'b1;
                o_done.valid = adv;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_IDLE;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (adv) begin
                r_oval <= 1'b1;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Load a command, then walk text, groups and characters
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odata <= '{out_char: ch, last_of_run: ch_last};
        end
        if (o_pop) begin
            r_bank  <= i_head.bank;
            r_cnt   <= i_head.cnt;
            r_ngrp  <= i_head.ngrp;
            r_empty <= i_head.empty;
            r_tidx  <= (i_head.kind == K_TRL) ? TXT_W'(TRL_FIRST) : TXT_W'(HDR_FIRST);
            r_tlast <= (i_head.kind == K_TRL) ? TXT_W'(TRL_LAST) : TXT_W'(HDR_LAST);
        end
        if (adv) begin
            unique case (r_st)
                B_TEXT: r_tidx <= r_tidx + TXT_W'(1);
                B_LEN: begin
                    r_gidx <= '0;
                    r_cidx <= '0;
                end
                B_GROUP: begin
                    r_cidx <= r_cidx + 2'd1;
                    if (r_cidx == 2'd3) begin
                        r_gidx <= r_gidx + GRP_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Line store: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    a_group_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == B_GROUP |-> r_gidx < r_ngrp)
        else $error("group index beyond line");

    a_release_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.valid |=> r_st == B_IDLE && r_oval && r_odata.last_of_run)
        else $error("bank released before line end");

endmodule

### rtl/core/uuencode_line_stream_encoder.sv
// Top level of the uuencode line encoder: front end, command queue and back end.
// Depends on uue_pkg, uue_front, uue_queue and uue_back.
//
// Input channel (i_valid/o_ready, i_data): one action per transfer - begin, data
// byte, end of data or trailer. Out-of-order actions are taken and dropped.
// Output channel (o_valid/i_ready, o_data): one text character per transfer;
// last_of_run marks the final character caused by one input transfer.
// Data bytes are packed three to a 24-bit word into a two-bank line store, so one
// line is filled while the previous one is sent. Input transfers go at one per
// cycle until a line completes while the other bank is still being sent or the
// command queue is full. Output runs at one character per cycle while the
// receiver is ready, apart from the idle state in which each command is popped.
// The first character of a transfer passes the command queue, the back end's
// idle state and the output register. When the receiver stalls the output
// register holds, the back end stops, the queue fills and o_ready falls.
// Synchronous reset returns to the idle phase awaiting begin and empties queue
// and output; the line store is not cleared.
module uuencode_line_stream_encoder #(
    parameter int BYTES_PER_LINE = uue_pkg::BPL_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  uue_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output uue_pkg::t_out o_data
);
    import uue_pkg::*;

    logic  push, pop, q_full, q_empty;
    t_cmd  cmd, head;
    t_wr   wr;
    t_done done;

    uue_front #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .o_cmd   (cmd),
        .i_q_full(q_full),
        .o_wr    (wr),
        .i_done  (done)
    );

    uue_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_head (head)
    );

    uue_back #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_wr     (wr),
        .o_done   (done),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

endmodule

### dv/tb_uuencode_line_stream_encoder.sv
// Testbench for uuencode_line_stream_encoder: directed and random action streams,
// with every output character checked against an in-bench prediction of the text.
// Depends on uue_pkg and the encoder RTL only.
module tb_uuencode_line_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import uue_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int LINE_BYTES    = BPL_DEFAULT;
    localparam int RANDOM_ITEMS  = 170;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int MAX_REPORTS   = 100;

    // Receiver stall patterns
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PULSE,
        SINK_CHOKE
    } t_sink_mode;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_in   i_data  = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    t_out  o_data;

    // Encoder state as predicted from the accepted transfers
    t_phase     enc_phase;
    logic [5:0] enc_count;
    logic       enc_seen;
    logic [7:0] enc_line [64];
    t_out       expected_chars [$];

    int error_count  = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    t_sink_mode sink_mode = SINK_OPEN;

    uuencode_line_stream_encoder #(
        .BYTES_PER_LINE(LINE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // ---------------------------------------------------------------- prediction

    task automatic push_char(input logic [7:0] c);
        t_out ch;
        ch.out_char    = c;
        ch.last_of_run = 1'b0;
        expected_chars.push_back(ch);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Length char, zero-padded groups of three bytes as four 6-bit chars, quote, newline
    task automatic predict_encoded_line();
        int          pos;
        logic [23:0] word;
        pos = 0;
        push_char(CH_SPACE + {2'b00, enc_count});
        do begin
            word = '0;
            for (int k = 0; k < 3; k++) begin
                if (pos < enc_count) begin
                    word = {word[15:0], enc_line[pos]};
                    pos++;
                end else begin
                    word = {word[15:0], 8'h00};
                end
            end
            for (int s = 18; s >= 0; s -= 6)
                push_char(CH_SPACE + {2'b00, word[s +: 6]});
        end while (pos < enc_count);
        push_char(CH_QUOTE);
        push_char(CH_NL);
    endtask

    task automatic predict_transfer(input t_in item);
        int   prior_size;
        t_out tail;
        prior_size = expected_chars.size();
        case (item.action)
            ACT_BEGIN: begin
                if (enc_phase == PH_IDLE || enc_phase == PH_DONE) begin
                    push_text("begin 666 -\n");
                    enc_count = '0;
                    enc_seen  = 1'b0;
                    enc_phase = PH_DATA;
                end
            end
            ACT_DATA: begin
                if (enc_phase == PH_DATA) begin
                    enc_line[enc_count] = item.data_byte;
                    enc_count = enc_count + 6'd1;
                    enc_seen  = 1'b1;
                    if (enc_count >= LINE_BYTES) begin
                        predict_encoded_line();
                        enc_count = '0;
                    end
                end
            end
            ACT_END: begin
                if (enc_phase == PH_DATA) begin
                    // a full last line leaves nothing to flush
                    if (enc_count != 0 || !enc_seen)
                        predict_encoded_line();
                    enc_count = '0;
                    enc_phase = PH_ENDED;
                end
            end
            default: begin
                if (enc_phase == PH_ENDED) begin
                    push_char(CH_QUOTE);
                    push_char(CH_NL);
                    push_text("end\n");
                    enc_phase = PH_DONE;
                end
            end
        endcase
        // flag the final character of this transfer
        if (expected_chars.size() > prior_size) begin
            tail = expected_chars.pop_back();
            tail.last_of_run = 1'b1;
            expected_chars.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------ checking

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                          o_data.out_char, o_data.last_of_run));
            end else begin
                want = expected_chars.pop_front();
                if (o_data.out_char !== want.out_char)
                    report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                              o_data.out_char, want.out_char));
                if (o_data.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b (char 0x%02h)",
                                              o_data.last_of_run, want.last_of_run,
                                              want.out_char));
            end
        end
    end

    // Receiver: switch between open, coin-flip, pulsed and choked patterns
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            sink_mode  = t_sink_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (sink_mode)
            SINK_OPEN:  i_ready <= 1'b1;
            SINK_COIN:  i_ready <= ($urandom_range(0, 1) == 1);
            SINK_PULSE: i_ready <= (stall_left % 3 != 0);
            default:    i_ready <= (stall_left % 16 == 0);
        endcase
    end

    // ------------------------------------------------------------------ stimulus

    // Send one action; bursts of random length with random gaps between them
    task automatic send_item(input t_action act, input logic [7:0] b);
        t_in item;
        int  gap;
        item.action    = act;
        item.data_byte = b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        predict_transfer(item);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // Well-formed stream; noisy ones carry stray begins and trailers among the data
    task automatic send_stream(input int nbytes, input bit with_trailer, input bit noisy);
        send_item(ACT_BEGIN, random_byte());
        for (int i = 0; i < nbytes; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(($urandom_range(0, 1) == 1) ? ACT_BEGIN : ACT_TRAILER,
                          random_byte());
            send_item(ACT_DATA, random_byte());
        end
        send_item(ACT_END, random_byte());
        if (with_trailer)
            send_item(ACT_TRAILER, random_byte());
    endtask

    // Out-of-order actions in every phase, and end with no data at all
    task automatic test_ignored_actions();
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_END, 8'hff);
        send_item(ACT_TRAILER, 8'h00);
        send_item(ACT_BEGIN, 8'hff);
        send_item(ACT_BEGIN, 8'h00);
        send_item(ACT_TRAILER, 8'h5a);
        send_item(ACT_END, 8'ha5);
        send_item(ACT_BEGIN, 8'h00);
        send_item(ACT_DATA, 8'hff);
        send_item(ACT_END, 8'h00);
        send_item(ACT_TRAILER, 8'hff);
        send_item(ACT_DATA, 8'h33);
        send_item(ACT_END, 8'hcc);
        send_item(ACT_TRAILER, 8'h00);
    endtask

    // Partial last lines of one and four bytes, extreme byte values
    task automatic test_partial_lines();
        send_item(ACT_BEGIN, 8'h00);
        send_item(ACT_DATA, 8'hff);
        send_item(ACT_END, 8'h00);
        send_item(ACT_TRAILER, 8'h00);
        send_item(ACT_BEGIN, 8'h00);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'h55);
        send_item(ACT_DATA, 8'haa);
        send_item(ACT_DATA, 8'h80);
        send_item(ACT_END, 8'h00);
        send_item(ACT_TRAILER, 8'h00);
    endtask

    // Exactly one full line: end after it must emit nothing
    task automatic test_full_line();
        send_stream(LINE_BYTES, 1'b1, 1'b0);
    endtask

    task automatic test_random_streams();
        int stop_at;
        int nbytes;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                // loose random actions
                repeat ($urandom_range(1, 4))
                    send_item(t_action'($urandom_range(0, 3)), random_byte());
            end else begin
                case ($urandom_range(0, 9))
                    0:       nbytes = 0;
                    1:       nbytes = $urandom_range(1, 3);
                    2, 3:    nbytes = $urandom_range(LINE_BYTES - 1, LINE_BYTES + 1);
                    4:       nbytes = $urandom_range(2 * LINE_BYTES - 1, 2 * LINE_BYTES + 1);
                    default: nbytes = $urandom_range(0, 20);
                endcase
                send_stream(nbytes, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // ---------------------------------------------------------------- test flow

    initial begin
        enc_phase = PH_IDLE;
        enc_count = '0;
        enc_seen  = 1'b0;
        for (int i = 0; i < 64; i++)
            enc_line[i] = 8'h00;

        // hold reset, release at an edge
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_actions();
        test_partial_lines();
        test_full_line();
        test_random_streams();

        // drain the remaining text, then watch for stray characters
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/uue_pkg.sv
rtl/core/uue_front.sv
rtl/core/uue_queue.sv
rtl/core/uue_back.sv
rtl/core/uuencode_line_stream_encoder.sv
dv/tb_uuencode_line_stream_encoder.sv
